FILE: rtl/ps2scd_pkg.sv
// constants and types shared by the ps2 scan code decoder
`timescale 1ns / 1ps
`default_nettype none
package ps2scd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned CodeW = 7;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [KindW-1:0] kind_t;
  typedef logic [CodeW-1:0] code_t;

  // event kinds
  localparam kind_t KIND_KEY     = 2'd0;
  localparam kind_t KIND_PASS    = 2'd1;
  localparam kind_t KIND_UNKNOWN = 2'd2;
  localparam kind_t KIND_E1_ERR  = 2'd3;

  // received bytes with a meaning of their own
  localparam byte_t BYTE_PASS     = 8'hAA;
  localparam byte_t BYTE_ERR_A    = 8'h00;
  localparam byte_t BYTE_ERR_B    = 8'hFF;
  localparam byte_t BYTE_ECHO     = 8'hEE;
  localparam byte_t BYTE_ACK      = 8'hFA;
  localparam byte_t BYTE_RESEND   = 8'hFE;
  localparam byte_t BYTE_STFAIL_A = 8'hFC;
  localparam byte_t BYTE_STFAIL_B = 8'hFD;
  localparam byte_t BYTE_F7       = 8'h83;
  localparam byte_t CODE_F7       = 8'h02;
  localparam byte_t BYTE_EXT      = 8'hE0;
  localparam byte_t BYTE_DOUBLE   = 8'hE1;
  localparam byte_t BYTE_REL      = 8'hF0;

  localparam code_t PAUSE_FIRST  = 7'h14;
  localparam code_t PAUSE_SECOND = 7'h77;
  localparam code_t CODE_PAUSE   = 7'h0F;

endpackage
`default_nettype wire

FILE: rtl/ps2scd_if.sv
// valid/ready channels for raw scan bytes and decoded events
`timescale 1ns / 1ps
`default_nettype none
interface ps2scd_byte_if;
  import ps2scd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink (input valid, input scan_byte, output ready);
endinterface

interface ps2scd_event_if;
  import ps2scd_pkg::*;

  logic  valid;
  logic  ready;
  kind_t event_kind;
  code_t key_code;
  logic  extended;
  logic  released;

  modport source (output valid, output event_kind, output key_code,
                  output extended, output released, input ready);
  modport sink (input valid, input event_kind, input key_code,
                input extended, input released, output ready);
endinterface
`default_nettype wire

FILE: rtl/ps2_scan_code_decoder.sv
// ps2 scan code set 2 byte decoder
// usage:
//   scan   : sink channel, one raw keyboard byte per transfer
//   events : source channel, at most one decoded event per input byte
//   event_kind 0 key, 1 self-test passed, 2 unknown code, 3 bad E1 pair
//   prefix bytes (E0, F0, E1) and the first byte of an E1 pair update the
//   prefix state and give no event; error/ack/echo/resend bytes are dropped
// timing:
//   one byte is taken per cycle while scan.ready is high; the event for a byte
//   appears on events in the cycle after its transfer, held in a single output register
//   the decode is a handful of byte compares against the prefix flags
// stall:
//   scan.ready stays high while the output register is empty or being
//   drained in the same cycle, so a stalled receiver backs up the input
//   after one pending event
// reset:
//   rst clears the prefix flags, the held E1 code and the output valid
`timescale 1ns / 1ps
`default_nettype none
module ps2_scan_code_decoder (
  input  wire logic      clk,
  input  wire logic      rst,
  ps2scd_byte_if.sink    scan,
  ps2scd_event_if.source events
);
  import ps2scd_pkg::*;

  logic  ext_flag, ext_flag_next;
  logic  rel_flag, rel_flag_next;
  logic  e1_pending, e1_pending_next;
  code_t e1_first_code, e1_first_code_next;

  logic  out_valid;
  kind_t out_kind;
  code_t out_code;
  logic  out_ext;
  logic  out_rel;

  logic  take;
  byte_t b;
  logic  emit;
  kind_t kind;
  code_t code;
  logic  ext;
  logic  rel;

  assign scan.ready = !out_valid || events.ready;
  assign take       = scan.valid && scan.ready;

  always_comb begin
    b                  = scan.scan_byte;
    emit               = 1'b0;
    kind               = KIND_KEY;
    code               = '0;
    ext                = 1'b0;
    rel                = 1'b0;
    ext_flag_next      = ext_flag;
    rel_flag_next      = rel_flag;
    e1_pending_next    = e1_pending;
    e1_first_code_next = e1_first_code;

    if (b == BYTE_F7) begin
      b = CODE_F7;
    end

    if (scan.scan_byte == BYTE_PASS) begin
      emit = 1'b1;
      kind = KIND_PASS;
    end else if (scan.scan_byte == BYTE_ERR_A || scan.scan_byte == BYTE_ERR_B ||
                 scan.scan_byte == BYTE_ECHO || scan.scan_byte == BYTE_ACK ||
                 scan.scan_byte == BYTE_RESEND || scan.scan_byte == BYTE_STFAIL_A ||
                 scan.scan_byte == BYTE_STFAIL_B) begin
      emit = 1'b0;
    end else if (b == BYTE_EXT) begin
      ext_flag_next = 1'b1;
    end else if (b == BYTE_DOUBLE) begin
      e1_pending_next = 1'b1;
    end else if (b == BYTE_REL) begin
      rel_flag_next = 1'b1;
    end else if (!b[ByteW-1]) begin
      if (e1_pending) begin
        // first code of an E1 pair is held until the second arrives
        e1_first_code_next = b[CodeW-1:0];
        e1_pending_next    = 1'b0;
      end else begin
        emit               = 1'b1;
        ext_flag_next      = 1'b0;
        rel_flag_next      = 1'b0;
        e1_first_code_next = '0;
        if (e1_first_code != '0 &&
            !(e1_first_code == PAUSE_FIRST && b[CodeW-1:0] == PAUSE_SECOND)) begin
          kind = KIND_E1_ERR;
          code = b[CodeW-1:0];
        end else begin
          kind = KIND_KEY;
          code = (e1_first_code != '0) ? CODE_PAUSE : b[CodeW-1:0];
          ext  = ext_flag;
          rel  = rel_flag;
        end
      end
    end else begin
      // unknown high code, prefix state kept
      emit = 1'b1;
      kind = KIND_UNKNOWN;
      code = b[CodeW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_flag      <= 1'b0;
      rel_flag      <= 1'b0;
      e1_pending    <= 1'b0;
      e1_first_code <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        ext_flag      <= ext_flag_next;
        rel_flag      <= rel_flag_next;
        e1_pending    <= e1_pending_next;
        e1_first_code <= e1_first_code_next;
      end
      if (scan.ready) begin
        out_valid <= take && emit;
      end
    end
  end

  // payload register, loaded only when a new event is captured
  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_kind <= kind;
      out_code <= code;
      out_ext  <= ext;
      out_rel  <= rel;
    end
  end

  assign events.valid      = out_valid;
  assign events.event_kind = out_kind;
  assign events.key_code   = out_code;
  assign events.extended   = out_ext;
  assign events.released   = out_rel;

endmodule
`default_nettype wire

FILE: verif/ps2_scan_code_decoder_tb.sv
// self-checking testbench for the ps2 scan code decoder: directed and random byte streams
`timescale 1ns / 1ps
module ps2_scan_code_decoder_tb;
  import ps2scd_pkg::*;

  localparam int unsigned RandomBytes = 1800;
  localparam int unsigned QuietFrom   = 1500;
  localparam int unsigned HoldAt      = 600;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 400000;

  typedef struct packed {
    kind_t kind;
    code_t code;
    logic  ext;
    logic  rel;
  } key_event_t;

  class event_scoreboard;
    key_event_t pending_events[$];
    logic  ext_seen;
    logic  rel_seen;
    logic  e1_armed;
    code_t e1_code;
    int    errors;
    int    pauses;
    int    kind_count[4];

    function new();
      ext_seen = 1'b0;
      rel_seen = 1'b0;
      e1_armed = 1'b0;
      e1_code  = '0;
      errors   = 0;
      pauses   = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function void expect_event(kind_t k, code_t c, logic x, logic r);
      key_event_t ev;
      ev.kind = k;
      ev.code = c;
      ev.ext  = x;
      ev.rel  = r;
      pending_events.push_back(ev);
    endfunction

    // returns 0 for bytes the decoder drops outright
    function bit note_byte(byte_t raw);
      byte_t b;
      code_t c;
      b = raw;
      case (b)
        BYTE_PASS: begin
          expect_event(KIND_PASS, '0, 1'b0, 1'b0);
          return 1'b1;
        end
        BYTE_ERR_A, BYTE_ERR_B, BYTE_ECHO, BYTE_ACK, BYTE_RESEND,
        BYTE_STFAIL_A, BYTE_STFAIL_B:
          return 1'b0;
        default: ;
      endcase
      if (b == BYTE_F7) b = CODE_F7;
      if (b == BYTE_EXT) begin
        ext_seen = 1'b1;
      end else if (b == BYTE_DOUBLE) begin
        e1_armed = 1'b1;
      end else if (b == BYTE_REL) begin
        rel_seen = 1'b1;
      end else if (!b[7]) begin
        c = b[CodeW-1:0];
        if (e1_armed) begin
          e1_code  = c;
          e1_armed = 1'b0;
        end else if (e1_code != '0 && !(e1_code == PAUSE_FIRST && c == PAUSE_SECOND)) begin
          expect_event(KIND_E1_ERR, c, 1'b0, 1'b0);
          ext_seen = 1'b0;
          rel_seen = 1'b0;
          e1_code  = '0;
        end else begin
          if (e1_code != '0) begin
            c = CODE_PAUSE;
            pauses++;
          end
          expect_event(KIND_KEY, c, ext_seen, rel_seen);
          ext_seen = 1'b0;
          rel_seen = 1'b0;
          e1_code  = '0;
        end
      end else begin
        // unknown high code leaves the prefix state alone
        expect_event(KIND_UNKNOWN, b[CodeW-1:0], 1'b0, 1'b0);
      end
      return 1'b1;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_event(kind_t k, code_t c, logic x, logic r);
      key_event_t want;
      if (pending_events.size() == 0) begin
        report($sformatf("event kind %0d code %02h with none pending", k, c));
      end else begin
        want = pending_events.pop_front();
        kind_count[k]++;
        if (k !== want.kind) report($sformatf("event_kind %0d, want %0d", k, want.kind));
        if (c !== want.code) report($sformatf("key_code %02h, want %02h", c, want.code));
        if (x !== want.ext) report($sformatf("extended %b, want %b", x, want.ext));
        if (r !== want.rel) report($sformatf("released %b, want %b", r, want.rel));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  ps2scd_byte_if  scan_ch();
  ps2scd_event_if event_ch();

  ps2_scan_code_decoder uut (
    .clk    (clk),
    .rst    (rst),
    .scan   (scan_ch),
    .events (event_ch)
  );

  event_scoreboard sb;
  bit quiet;
  bit hold_request;
  int sent_bytes;
  int decoded_bytes;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // event receiver: random stall bursts plus one long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    event_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (event_ch.valid === 1'b1 && event_ch.ready === 1'b1)
        sb.check_event(event_ch.event_kind, event_ch.key_code,
                       event_ch.extended, event_ch.released);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HoldCycles;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        stall_left--;
        event_ch.ready <= 1'b0;
      end else begin
        event_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  task automatic send_byte(input byte_t b);
    scan_ch.valid     <= 1'b1;
    scan_ch.scan_byte <= b;
    do @(posedge clk); while (scan_ch.ready !== 1'b1);
    sent_bytes++;
    if (sb.note_byte(b)) decoded_bytes++;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      scan_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  function automatic byte_t random_literal();
    if ($urandom_range(0, 19) == 0) return BYTE_F7;
    return byte_t'($urandom_range(1, 127));
  endfunction

  function automatic byte_t random_noise();
    return byte_t'($urandom_range(0, 255));
  endfunction

  task automatic play_random_sequence();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      if ($urandom_range(0, 2) == 0) send_byte(BYTE_EXT);
      if ($urandom_range(0, 9) == 0) send_byte(random_noise());
      if ($urandom_range(0, 2) == 0) send_byte(BYTE_REL);
      send_byte(random_literal());
    end else if (pick < 65) begin
      // pause sequence, sometimes with prefixes mixed in
      if ($urandom_range(0, 3) == 0) send_byte(BYTE_EXT);
      send_byte(BYTE_DOUBLE);
      send_byte({1'b0, PAUSE_FIRST});
      if ($urandom_range(0, 1) == 0) send_byte(BYTE_REL);
      send_byte({1'b0, PAUSE_SECOND});
    end else if (pick < 78) begin
      // e1 pair with random content, mostly a bad pair
      send_byte(BYTE_DOUBLE);
      if ($urandom_range(0, 7) == 0) send_byte(random_noise());
      send_byte(random_literal());
      if ($urandom_range(0, 7) == 0) send_byte(random_noise());
      send_byte(random_literal());
    end else begin
      send_byte(random_noise());
    end
  endtask

  initial begin
    byte_t opening[$];
    int random_start;
    bit held;
    opening = '{
      BYTE_PASS, BYTE_ERR_A, BYTE_ERR_B, BYTE_ECHO, BYTE_ACK, BYTE_RESEND,
      BYTE_STFAIL_A, BYTE_STFAIL_B, BYTE_F7, 8'h1C,
      BYTE_EXT, 8'h75, BYTE_REL, 8'h1C, BYTE_EXT, BYTE_REL, 8'h75,
      BYTE_DOUBLE, {1'b0, PAUSE_FIRST}, {1'b0, PAUSE_SECOND},
      BYTE_DOUBLE, {1'b0, PAUSE_FIRST}, BYTE_REL, {1'b0, PAUSE_SECOND},
      BYTE_DOUBLE, 8'h12, 8'h34, 8'h80, 8'h85, 8'h7F, BYTE_EXT, BYTE_EXT, 8'h01
    };
    sb = new;
    quiet = 1'b0;
    hold_request = 1'b0;
    held = 1'b0;
    sent_bytes = 0;
    decoded_bytes = 0;
    rst <= 1'b1;
    scan_ch.valid <= 1'b0;
    scan_ch.scan_byte <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening[i]) send_byte(opening[i]);

    random_start = decoded_bytes;
    while (decoded_bytes - random_start < RandomBytes) begin
      if (!held && decoded_bytes - random_start >= HoldAt) begin
        held = 1'b1;
        hold_request = 1'b1;
      end
      if (decoded_bytes - random_start >= QuietFrom) quiet = 1'b1;
      play_random_sequence();
    end
    scan_ch.valid <= 1'b0;

    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d bytes (%0d decoded) in %0d cycles, including a %0d-cycle output hold",
             sent_bytes, decoded_bytes, cycles, HoldCycles);
    $display("events checked: key %0d (pause %0d), self-test %0d, unknown %0d, bad e1 %0d",
             sb.kind_count[KIND_KEY], sb.pauses, sb.kind_count[KIND_PASS],
             sb.kind_count[KIND_UNKNOWN], sb.kind_count[KIND_E1_ERR]);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
